@@ rtl/core/cdsg_pkg.sv @@
package cdsg_pkg;

    localparam int DAY_NUMBER_W = 22;
    localparam int YEAR_W       = 14;
    localparam int MONTH_W      = 4;
    localparam int DAY_W        = 5;
    localparam int WEEKDAY_W    = 3;
    localparam int WEEK_W       = 3;
    localparam int WEEK_END_W   = 4;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 22;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_BEGIN_DAY_NUMBER = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_END_DAY_NUMBER   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BEGIN_YEAR       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BEGIN_MONTH      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BEGIN_DAY        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BEGIN_WEEKDAY    = 3'd5;

    // Reset values: 2000-01-01, a Saturday, through 2000-12-31.
    localparam logic [DAY_NUMBER_W-1:0] RST_BEGIN_DAY_NUMBER = 22'd730120;
    localparam logic [DAY_NUMBER_W-1:0] RST_END_DAY_NUMBER   = 22'd730485;
    localparam logic [YEAR_W-1:0]       RST_BEGIN_YEAR       = 14'd2000;
    localparam logic [MONTH_W-1:0]      RST_BEGIN_MONTH      = 4'd1;
    localparam logic [DAY_W-1:0]        RST_BEGIN_DAY        = 5'd1;
    localparam logic [WEEKDAY_W-1:0]    RST_BEGIN_WEEKDAY    = 3'd6;

    typedef struct packed {
        logic [DAY_NUMBER_W-1:0] day_number;
        logic [YEAR_W-1:0]       year;
        logic [MONTH_W-1:0]      month;
        logic [DAY_W-1:0]        day;
        logic [WEEKDAY_W-1:0]    weekday;
    } date_t;

    typedef struct packed {
        date_t                   begin_date;
        logic [DAY_NUMBER_W-1:0] end_day_number;
    } cfg_t;

    typedef struct packed {
        date_t                        date;
        logic [WEEK_W-1:0]            week_of_month;
        logic signed [WEEK_END_W-1:0] week_from_end;
        logic                         last_of_month;
        logic                         last_of_range;
    } day_rec_t;

endpackage

@@ rtl/core/cdsg_tick_if.sv @@
interface cdsg_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

@@ rtl/core/cdsg_day_if.sv @@
interface cdsg_day_if;
    logic                                         valid;
    logic                                         ready;
    logic [cdsg_pkg::DAY_NUMBER_W-1:0]            day_number;
    logic [cdsg_pkg::YEAR_W-1:0]                  year;
    logic [cdsg_pkg::MONTH_W-1:0]                 month;
    logic [cdsg_pkg::DAY_W-1:0]                   day_of_month;
    logic [cdsg_pkg::WEEKDAY_W-1:0]               weekday;
    logic [cdsg_pkg::WEEK_W-1:0]                  week_of_month;
    logic signed [cdsg_pkg::WEEK_END_W-1:0]       week_from_end;
    logic                                         last_of_month;
    logic                                         last_of_range;

    modport source (
        output valid, output day_number, output year, output month,
        output day_of_month, output weekday, output week_of_month,
        output week_from_end, output last_of_month, output last_of_range,
        input ready
    );
    modport sink (
        input valid, input day_number, input year, input month,
        input day_of_month, input weekday, input week_of_month,
        input week_from_end, input last_of_month, input last_of_range,
        output ready
    );
endinterface

@@ rtl/core/cdsg_cfg_regs.sv @@
module cdsg_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cdsg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cdsg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    output cdsg_pkg::cfg_t                     cfg
);

    cdsg_pkg::cfg_t cfg_reg;
    cdsg_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                cdsg_pkg::REG_BEGIN_DAY_NUMBER:
                    cfg_next.begin_date.day_number = cfg_wdata[cdsg_pkg::DAY_NUMBER_W-1:0];
                cdsg_pkg::REG_END_DAY_NUMBER:
                    cfg_next.end_day_number = cfg_wdata[cdsg_pkg::DAY_NUMBER_W-1:0];
                cdsg_pkg::REG_BEGIN_YEAR:
                    cfg_next.begin_date.year = cfg_wdata[cdsg_pkg::YEAR_W-1:0];
                cdsg_pkg::REG_BEGIN_MONTH:
                    cfg_next.begin_date.month = cfg_wdata[cdsg_pkg::MONTH_W-1:0];
                cdsg_pkg::REG_BEGIN_DAY:
                    cfg_next.begin_date.day = cfg_wdata[cdsg_pkg::DAY_W-1:0];
                cdsg_pkg::REG_BEGIN_WEEKDAY:
                    cfg_next.begin_date.weekday = cfg_wdata[cdsg_pkg::WEEKDAY_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.begin_date.day_number <= cdsg_pkg::RST_BEGIN_DAY_NUMBER;
            cfg_reg.begin_date.year       <= cdsg_pkg::RST_BEGIN_YEAR;
            cfg_reg.begin_date.month      <= cdsg_pkg::RST_BEGIN_MONTH;
            cfg_reg.begin_date.day        <= cdsg_pkg::RST_BEGIN_DAY;
            cfg_reg.begin_date.weekday    <= cdsg_pkg::RST_BEGIN_WEEKDAY;
            cfg_reg.end_day_number        <= cdsg_pkg::RST_END_DAY_NUMBER;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/core/cdsg_step.sv @@
module cdsg_step (
    input  cdsg_pkg::date_t                    cur,
    input  cdsg_pkg::cfg_t                     cfg,
    output cdsg_pkg::day_rec_t                 rec,
    output cdsg_pkg::date_t                    nxt
);

    // Seven-day groups in a value of at most 31.
    function automatic logic [2:0] div7(input logic [4:0] d);
        logic [2:0] q;
        if (d >= 5'd28)
            q = 3'd4;
        else if (d >= 5'd21)
            q = 3'd3;
        else if (d >= 5'd14)
            q = 3'd2;
        else if (d >= 5'd7)
            q = 3'd1;
        else
            q = 3'd0;
        return q;
    endfunction

    logic [24:0] yr_prod;
    logic [9:0]  yr_q25;
    logic [13:0] yr_rem_raw;
    logic [5:0]  yr_rem;
    logic [5:0]  yr_mod25;
    logic        leap;
    logic [4:0]  mlen;
    logic        last_m;
    logic        last_r;
    logic [4:0]  days_left;
    logic [2:0]  back;
    logic [2:0]  wom;

    // Year mod 25 by a reciprocal multiply. 1310/2^15 sits just below 1/25,
    // so the quotient is exact or one short and the remainder stays below 50.
    always_comb
    begin
        yr_prod    = 25'(cur.year) * 25'd1310;
        yr_q25     = yr_prod[24:15];
        yr_rem_raw = cur.year - (14'(yr_q25) << 4) - (14'(yr_q25) << 3) - 14'(yr_q25);
        yr_rem     = yr_rem_raw[5:0];
        yr_mod25   = (yr_rem >= 6'd25) ? (yr_rem - 6'd25) : yr_rem;
        // Divisible by 4, and either not by 100 or also by 400 (16 and 25).
        leap = (cur.year[1:0] == 2'd0) && ((yr_mod25 != 6'd0) || (cur.year[3:0] == 4'd0));
    end

    always_comb
    begin
        case (cur.month)
            4'd4, 4'd6, 4'd9, 4'd11: mlen = 5'd30;
            4'd2:                    mlen = leap ? 5'd29 : 5'd28;
            default:                 mlen = 5'd31;
        endcase
    end

    always_comb
    begin
        last_m    = (cur.day >= mlen);
        last_r    = (cur.day_number == cfg.end_day_number);
        days_left = mlen - cur.day;
        back      = last_m ? 3'd1 : (div7(days_left) + 3'd1);
        wom       = (cur.day == 5'd0) ? 3'd1 : (div7(cur.day - 5'd1) + 3'd1);

        rec.date          = cur;
        rec.week_of_month = wom;
        rec.week_from_end = $signed(4'd0 - {1'b0, back});
        rec.last_of_month = last_m;
        rec.last_of_range = last_r;
    end

    always_comb
    begin
        nxt = cur;
        if (last_r)
        begin
            nxt = cfg.begin_date;
        end
        else
        begin
            nxt.day_number = cur.day_number + 22'd1;
            nxt.weekday    = (cur.weekday >= 3'd6) ? 3'd0 : (cur.weekday + 3'd1);
            if (last_m)
            begin
                nxt.day = 5'd1;
                if ((cur.month >= 4'd12) || (cur.month == 4'd0))
                begin
                    nxt.month = 4'd1;
                    nxt.year  = cur.year + 14'd1;
                end
                else
                begin
                    nxt.month = cur.month + 4'd1;
                end
            end
            else
            begin
                nxt.day = cur.day + 5'd1;
            end
        end
    end

endmodule

@@ rtl/core/calendar_day_sequence_generator_core.sv @@
// Calendar day sequence generator. Every beat on the tick channel yields
// exactly one beat on the day channel describing the current day of the
// proleptic Gregorian calendar, after which the block steps to the next day;
// when the emitted day is the configured end day, it wraps to the configured
// begin date. A tick with restart set reloads the begin date before the day
// is described. The block takes one tick per clock cycle with no bubbles: the
// record for a tick appears in the output register on the cycle after the
// tick is taken, and a new tick is taken in the same cycle that the previous
// record is drained. The cycle time is set by the single step path from the
// current-date register through the leap-year check (a small constant
// multiply), the month length table and the next-date logic. Register writes
// only change the begin and end settings; the running date picks up the begin
// date on a restart or a wrap. Software supplies the begin date already split
// into year, month, day and weekday, consistent with its day number.
module calendar_day_sequence_generator_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cdsg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [cdsg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    cdsg_tick_if.sink                          tick,
    cdsg_day_if.source                         day
);

    cdsg_pkg::cfg_t     cfg;
    cdsg_pkg::date_t    cur_reg;
    cdsg_pkg::date_t    cur_next;
    cdsg_pkg::date_t    step_in;
    cdsg_pkg::date_t    step_nxt;
    cdsg_pkg::day_rec_t step_rec;
    cdsg_pkg::day_rec_t rec_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               tick_ready;
    logic               tick_take;

    cdsg_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // A restart replaces the running date with the begin date for this beat.
    assign step_in = tick.restart ? cfg.begin_date : cur_reg;

    cdsg_step u_step (
        .cur (step_in),
        .cfg (cfg),
        .rec (step_rec),
        .nxt (step_nxt)
    );

    // The output register frees up in the same cycle its beat is taken, so
    // a tick is accepted whenever the register is empty or being drained.
    assign tick_ready = !out_valid_reg || day.ready;
    assign tick_take  = tick.valid && tick_ready;
    assign tick.ready = tick_ready;

    always_comb
    begin
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg;
        if (tick_take)
        begin
            cur_next       = step_nxt;
            out_valid_next = 1'b1;
        end
        else if (day.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // The running date comes out of reset at the reset begin date.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg.day_number <= cdsg_pkg::RST_BEGIN_DAY_NUMBER;
            cur_reg.year       <= cdsg_pkg::RST_BEGIN_YEAR;
            cur_reg.month      <= cdsg_pkg::RST_BEGIN_MONTH;
            cur_reg.day        <= cdsg_pkg::RST_BEGIN_DAY;
            cur_reg.weekday    <= cdsg_pkg::RST_BEGIN_WEEKDAY;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload is loaded only on an accepted tick.
    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            rec_reg <= step_rec;
        end
    end

    assign day.valid         = out_valid_reg;
    assign day.day_number    = rec_reg.date.day_number;
    assign day.year          = rec_reg.date.year;
    assign day.month         = rec_reg.date.month;
    assign day.day_of_month  = rec_reg.date.day;
    assign day.weekday       = rec_reg.date.weekday;
    assign day.week_of_month = rec_reg.week_of_month;
    assign day.week_from_end = rec_reg.week_from_end;
    assign day.last_of_month = rec_reg.last_of_month;
    assign day.last_of_range = rec_reg.last_of_range;

endmodule
